>>> hw/rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared constants, types and the witness table for the primality tester
// ----------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;

   localparam int VALUE_WIDTH_DEF = 63;
   localparam int BASE_COUNT_DEF  = 12;
   localparam int BASE_TOTAL      = 12;
   localparam int BASE_IDX_W      = 4;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture candidate, form n-1
      logic strip;      // shift one trailing zero off d
      logic base_init;  // start a new base: acc=1, sq=a, e=d, t=d
      logic mul_acc;    // start acc = acc*sq
      logic mul_sq;     // start sq = sq*sq
      logic shift_e;    // e >>= 1
      logic mul_y;      // start y = y*y (y lives in acc)
      logic shift_t;    // t <<= 1
   } mrpt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_le1;
      logic n_two;
      logic n_even;
      logic d_even;
      logic base_ge_n;
      logic e_zero;
      logic e_odd;
      logic mul_busy;
      logic t_is_nm1;
      logic y_one;
      logic y_nm1;
      logic t_odd;
   } mrpt_sts_type;

   function automatic logic [5:0] witness(input logic [BASE_IDX_W-1:0] idx);
      logic [5:0] w;
      case (idx)
         4'd0:    w = 6'd2;
         4'd1:    w = 6'd3;
         4'd2:    w = 6'd5;
         4'd3:    w = 6'd7;
         4'd4:    w = 6'd11;
         4'd5:    w = 6'd13;
         4'd6:    w = 6'd17;
         4'd7:    w = 6'd19;
         4'd8:    w = 6'd23;
         4'd9:    w = 6'd29;
         4'd10:   w = 6'd31;
         4'd11:   w = 6'd37;
         default: w = 6'd37;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/miller_rabin_prime_test_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_top
// deterministic miller-rabin primality test of one unsigned candidate
// ----------------------------------------------------------------------------
// One beat in gives one beat out: rsp_prime_flag is 1 when req_candidate is
// prime. Up to BASE_COUNT witnesses (2 .. 37) are tried, exact for all values
// below 2^64 with all twelve. Items are taken one at a time; an item costs
// about BASES * 2 * VALUE_WIDTH modular products for a 63-bit prime, while
// even or tiny values finish after the special-case checks. The bit-serial
// modular multiplier sets the time that each product takes.
// The result register lets the next beat be accepted while a result waits.
`default_nettype none
module miller_rabin_prime_test_top #(
   parameter int VALUE_WIDTH = mrpt_pkg::VALUE_WIDTH_DEF,
   parameter int BASE_COUNT  = mrpt_pkg::BASE_COUNT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_prime_flag
);
   import mrpt_pkg::*;

   // command and status between sequencer and datapath
   mrpt_cmd_type           cmd;
   mrpt_sts_type           sts;
   logic [BASE_IDX_W-1:0]  base_idx;

   mrpt_ctrl #(.BASES(BASE_COUNT)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_prime_flag(rsp_prime_flag),
      .base_idx      (base_idx),
      .cmd           (cmd),
      .sts           (sts)
   );

   mrpt_datapath #(.W(VALUE_WIDTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .candidate(req_candidate),
      .base_idx (base_idx),
      .cmd      (cmd),
      .sts      (sts)
   );

   // only one multiply may be launched at a time
   a_one_mul: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mul_acc, cmd.mul_sq, cmd.mul_y}))
      else $error("two multiplies launched together");

   // no multiply starts while the unit is still busy
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_acc || cmd.mul_sq || cmd.mul_y) |-> !sts.mul_busy)
      else $error("multiply launched while busy");

   // a load only happens when an input beat is accepted
   a_load_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("operand load without accepted beat");
endmodule
`default_nettype wire

>>> hw/rtl/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_mulmod #(
   parameter int W = mrpt_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] x,
   input  wire logic [W-1:0] y,
   input  wire logic [W-1:0] m,
   output logic              busy,
   output logic [W-1:0]      product
);
   import mrpt_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, y_ff, y_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    dbl, dbl_r, add, add_r;

   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      add   = dbl_r + {1'b0, x_ff};
      add_r = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
      acc_in  = acc_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         y_in    = y;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = y_ff[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
         y_in    = {y_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      y_ff   <= y_in;
      if (start) x_ff <= x;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> hw/rtl/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// mrpt_datapath
// operand registers, witness selection and the shared modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_datapath #(
   parameter int W = mrpt_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [W-1:0]                    candidate,
   input  wire logic [mrpt_pkg::BASE_IDX_W-1:0] base_idx,
   input  wire mrpt_pkg::mrpt_cmd_type          cmd,
   output mrpt_pkg::mrpt_sts_type               sts
);
   import mrpt_pkg::*;

   logic [W-1:0] n_ff, nm1_ff, d_ff, e_ff, t_ff, acc_ff, sq_ff;
   logic [W-1:0] base_w, mx, my, prod;
   logic         busy, busy_q_ff;
   logic         tgt_acc_ff; // 1: result goes to acc, 0: to sq
   logic         done;

   assign base_w = W'(witness(base_idx));
   assign mx     = cmd.mul_sq ? sq_ff : acc_ff;
   assign my     = (cmd.mul_sq || cmd.mul_y) ? mx : sq_ff;
   assign done   = busy_q_ff && !busy;

   mrpt_mulmod #(.W(W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_acc || cmd.mul_sq || cmd.mul_y),
      .x      (mx),
      .y      (my),
      .m      (n_ff),
      .busy   (busy),
      .product(prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_q_ff <= 1'b0;
      end else begin
         busy_q_ff <= busy;
      end
      if (cmd.mul_acc || cmd.mul_y) tgt_acc_ff <= 1'b1;
      else if (cmd.mul_sq)          tgt_acc_ff <= 1'b0;
      if (cmd.load) begin
         n_ff   <= candidate;
         nm1_ff <= candidate - 1'b1;
         d_ff   <= candidate - 1'b1;
      end
      if (cmd.strip) d_ff <= d_ff >> 1;
      if (cmd.base_init) begin
         acc_ff <= W'(1);
         sq_ff  <= base_w;
         e_ff   <= d_ff;
         t_ff   <= d_ff;
      end
      if (cmd.shift_e) e_ff <= e_ff >> 1;
      if (cmd.shift_t) t_ff <= t_ff << 1;
      if (done) begin
         if (tgt_acc_ff) acc_ff <= prod;
         else            sq_ff  <= prod;
      end
   end

   always_comb begin
      sts.n_le1     = (n_ff <= W'(1));
      sts.n_two     = (n_ff == W'(2));
      sts.n_even    = !n_ff[0];
      sts.d_even    = !d_ff[0];
      sts.base_ge_n = (n_ff <= base_w);
      sts.e_zero    = (e_ff == '0);
      sts.e_odd     = e_ff[0];
      sts.mul_busy  = busy || busy_q_ff;
      sts.t_is_nm1  = (t_ff == nm1_ff);
      sts.y_one     = (acc_ff == W'(1));
      sts.y_nm1     = (acc_ff == nm1_ff);
      sts.t_odd     = t_ff[0];
   end
endmodule
`default_nettype wire

>>> hw/rtl/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mrpt_ctrl
// sequencer: special cases, base loop, exponentiation and squaring phases
// ----------------------------------------------------------------------------
`default_nettype none
module mrpt_ctrl #(
   parameter int BASES = mrpt_pkg::BASE_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_prime_flag,
   output logic [mrpt_pkg::BASE_IDX_W-1:0]      base_idx,
   output mrpt_pkg::mrpt_cmd_type               cmd,
   input  wire mrpt_pkg::mrpt_sts_type          sts
);
   import mrpt_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_CHECK = 10'b0000000010,
      ST_STRIP = 10'b0000000100,
      ST_BASE  = 10'b0000001000,
      ST_EXP   = 10'b0000010000,
      ST_WACC  = 10'b0000100000,
      ST_WSQ   = 10'b0001000000,
      ST_SQR   = 10'b0010000000,
      ST_WY    = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [BASE_IDX_W-1:0]   idx_ff, idx_in;
   logic                    valid_ff, valid_in, flag_ff, flag_in;
   logic                    out_flag_ff, out_flag_in;  // held result beat

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      valid_in    = valid_ff && rsp_stall;
      flag_in     = flag_ff;
      out_flag_in = out_flag_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in = '0;
            if (sts.n_le1) begin
               flag_in = 1'b0; state_in = ST_DONE;
            end else if (sts.n_two) begin
               flag_in = 1'b1; state_in = ST_DONE;
            end else if (sts.n_even) begin
               flag_in = 1'b0; state_in = ST_DONE;
            end else begin
               state_in = ST_STRIP;
            end
         end
         ST_STRIP: begin
            if (sts.d_even) cmd.strip = 1'b1;
            else            state_in = ST_BASE;
         end
         ST_BASE: begin
            if (idx_ff == BASE_IDX_W'(BASES) || sts.base_ge_n) begin
               flag_in = 1'b1; state_in = ST_DONE;
            end else begin
               cmd.base_init = 1'b1;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (sts.e_zero) begin
               state_in = ST_SQR;
            end else if (sts.e_odd) begin
               cmd.mul_acc = 1'b1; state_in = ST_WACC;
            end else begin
               cmd.mul_sq = 1'b1; state_in = ST_WSQ;
            end
         end
         ST_WACC: begin
            if (!sts.mul_busy) begin
               cmd.mul_sq = 1'b1; state_in = ST_WSQ;
            end
         end
         ST_WSQ: begin
            if (!sts.mul_busy) begin
               cmd.shift_e = 1'b1; state_in = ST_EXP;
            end
         end
         ST_SQR: begin
            if (!sts.t_is_nm1 && !sts.y_one && !sts.y_nm1) begin
               cmd.mul_y = 1'b1; cmd.shift_t = 1'b1; state_in = ST_WY;
            end else if (!sts.y_nm1 && !sts.t_odd) begin
               flag_in = 1'b0; state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = ST_BASE;
            end
         end
         ST_WY: begin
            if (!sts.mul_busy) state_in = ST_SQR;
         end
         ST_DONE: begin
            if (!valid_ff || !rsp_stall) begin
               valid_in    = 1'b1;
               out_flag_in = flag_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff      <= idx_in;
      flag_ff     <= flag_in;
      out_flag_ff <= out_flag_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_prime_flag = out_flag_ff;
   assign base_idx       = idx_ff;
endmodule
`default_nettype wire
